[rtl/core/drrp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package drrp_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TRUNCATED  = 2'd1,
        ST_BAD_PTR    = 2'd2,
        ST_BAD_CLASS  = 2'd3
    } t_status;

    typedef struct packed {
        t_status      status;
        logic [15:0]  rr_type;
        logic         flush_bit;
        logic [31:0]  time_to_live;
        logic [15:0]  data_length;
        logic [15:0]  data_offset;
        logic [15:0]  record_length;
    } t_result;

    localparam int          CLASS_W         = 15;
    localparam int          POINTER_W       = 14;
    // type, class, ttl and data length
    localparam logic [15:0] FIXED_BYTES     = 16'd10;
    // terminating root label plus the fixed fields
    localparam logic [15:0] NAME_END_BYTES  = 16'd11;
    localparam logic [15:0] POINTER_BYTES   = 16'd2;
    localparam logic [3:0]  HEADER_BYTES    = 4'd8;
    localparam logic [3:0]  CLASS_DONE_IDX  = 4'd4;
    localparam logic [3:0]  FIXED_DONE_IDX  = 4'd10;

endpackage

`default_nettype wire

[rtl/core/drrp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module drrp_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic                          i_first_byte,
    input  wire logic [15:0]                   i_record_offset,
    input  wire logic [15:0]                   i_bytes_available,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic [drrp_pkg::CLASS_W-1:0]  i_accepted_class,
    output logic                               o_result_valid,
    output drrp_pkg::t_result                  o_result
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_NAME    = 3'd1,
        PH_LABEL   = 3'd2,
        PH_POINTER = 3'd3,
        PH_FIXED   = 3'd4
    } t_phase;

    t_phase      r_phase,       n_phase,       e_phase;
    logic [15:0] r_bytes_left,  n_bytes_left,  e_bytes_left;
    logic [15:0] r_consumed,    n_consumed,    e_consumed;
    logic [5:0]  r_countdown,   n_countdown,   e_countdown;
    logic [15:0] r_start,       n_start,       e_start;
    logic [5:0]  r_ptr_high,    n_ptr_high,    e_ptr_high;
    logic [3:0]  r_fixed_idx,   n_fixed_idx,   e_fixed_idx;
    logic [63:0] r_fixed,       n_fixed,       e_fixed;
    logic [15:0] r_length,      n_length,      e_length;

    logic                     res_valid;
    drrp_pkg::t_result        res;
    logic [15:0]              left_less_one;
    logic [drrp_pkg::POINTER_W-1:0] target;

    always_comb begin
        // a first byte reloads the record context before the byte is parsed
        e_phase      = r_phase;
        e_bytes_left = r_bytes_left;
        e_consumed   = r_consumed;
        e_countdown  = r_countdown;
        e_start      = r_start;
        e_ptr_high   = r_ptr_high;
        e_fixed_idx  = r_fixed_idx;
        e_fixed      = r_fixed;
        e_length     = r_length;
        if (i_first_byte) begin
            e_phase      = PH_NAME;
            e_bytes_left = i_bytes_available;
            e_consumed   = '0;
            e_countdown  = '0;
            e_start      = i_record_offset;
            e_ptr_high   = '0;
            e_fixed_idx  = '0;
            e_fixed      = '0;
            e_length     = '0;
        end

        n_phase      = e_phase;
        n_bytes_left = e_bytes_left;
        n_consumed   = e_consumed + 16'd1;
        n_countdown  = e_countdown;
        n_start      = e_start;
        n_ptr_high   = e_ptr_high;
        n_fixed_idx  = e_fixed_idx;
        n_fixed      = e_fixed;
        n_length     = e_length;

        res_valid     = 1'b0;
        res           = '0;
        left_less_one = e_bytes_left - 16'd1;
        target        = {e_ptr_high, i_data_byte};

        case (e_phase)
            PH_NAME: begin
                if (i_data_byte == 8'd0) begin
                    if (e_bytes_left < drrp_pkg::NAME_END_BYTES) begin
                        res_valid  = 1'b1;
                        res.status = drrp_pkg::ST_TRUNCATED;
                    end else begin
                        n_bytes_left = e_bytes_left - drrp_pkg::NAME_END_BYTES;
                        n_fixed_idx  = '0;
                        n_phase      = PH_FIXED;
                    end
                end else if (i_data_byte[7:6] != 2'b00) begin
                    if (e_bytes_left < drrp_pkg::POINTER_BYTES) begin
                        res_valid  = 1'b1;
                        res.status = drrp_pkg::ST_TRUNCATED;
                    end else begin
                        n_bytes_left = left_less_one;
                        n_ptr_high   = i_data_byte[5:0];
                        n_phase      = PH_POINTER;
                    end
                end else begin
                    // label needs its length plus the length byte plus one more
                    if ({1'b0, e_bytes_left} < ({9'd0, i_data_byte} + 17'd2)) begin
                        res_valid  = 1'b1;
                        res.status = drrp_pkg::ST_TRUNCATED;
                    end else begin
                        n_bytes_left = e_bytes_left - ({8'd0, i_data_byte} + 16'd1);
                        n_countdown  = i_data_byte[5:0];
                        n_phase      = PH_LABEL;
                    end
                end
            end
            PH_LABEL: begin
                n_countdown = e_countdown - 6'd1;
                if (n_countdown == 6'd0) begin
                    n_phase = PH_NAME;
                end
            end
            PH_POINTER: begin
                n_bytes_left = left_less_one;
                if ({2'b00, target} >= e_start) begin
                    res_valid  = 1'b1;
                    res.status = drrp_pkg::ST_BAD_PTR;
                end else if (left_less_one < drrp_pkg::FIXED_BYTES) begin
                    res_valid  = 1'b1;
                    res.status = drrp_pkg::ST_TRUNCATED;
                end else begin
                    n_bytes_left = left_less_one - drrp_pkg::FIXED_BYTES;
                    n_fixed_idx  = '0;
                    n_phase      = PH_FIXED;
                end
            end
            PH_FIXED: begin
                if (e_fixed_idx < drrp_pkg::HEADER_BYTES) begin
                    n_fixed = {e_fixed[55:0], i_data_byte};
                end else begin
                    n_length = {e_length[7:0], i_data_byte};
                end
                n_fixed_idx = e_fixed_idx + 4'd1;
                if (n_fixed_idx == drrp_pkg::CLASS_DONE_IDX
                        && n_fixed[drrp_pkg::CLASS_W-1:0] != i_accepted_class) begin
                    res_valid  = 1'b1;
                    res.status = drrp_pkg::ST_BAD_CLASS;
                end else if (n_fixed_idx == drrp_pkg::FIXED_DONE_IDX) begin
                    res_valid = 1'b1;
                    if (n_length != 16'd0 && e_bytes_left < n_length) begin
                        res.status = drrp_pkg::ST_TRUNCATED;
                    end else begin
                        res.status        = drrp_pkg::ST_OK;
                        res.rr_type       = n_fixed[63:48];
                        res.flush_bit     = n_fixed[47];
                        res.time_to_live  = n_fixed[31:0];
                        res.data_length   = n_length;
                        res.data_offset   = n_consumed;
                        res.record_length = n_consumed + n_length;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // any result ends the record; bytes are ignored until the next first byte
        if (res_valid) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= '0;
            r_consumed   <= '0;
            r_countdown  <= '0;
            r_start      <= '0;
            r_ptr_high   <= '0;
            r_fixed_idx  <= '0;
            r_fixed      <= '0;
            r_length     <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_consumed   <= n_consumed;
            r_countdown  <= n_countdown;
            r_start      <= n_start;
            r_ptr_high   <= n_ptr_high;
            r_fixed_idx  <= n_fixed_idx;
            r_fixed      <= n_fixed;
            r_length     <= n_length;
        end
    end

    assign o_result_valid = i_accept && res_valid;
    assign o_result       = res;

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> r_phase == PH_IDLE)
        else $error("parser not idle after emitting a result");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != drrp_pkg::ST_OK)
        |-> (o_result.rr_type == 16'd0 && o_result.time_to_live == 32'd0
             && o_result.data_length == 16'd0 && o_result.record_length == 16'd0))
        else $error("error result carries non-zero fields");

    a_ok_from_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == drrp_pkg::ST_OK)
        |-> (e_phase == PH_FIXED && e_fixed_idx == drrp_pkg::FIXED_DONE_IDX - 4'd1))
        else $error("ok result before the last fixed byte");

    a_no_result_in_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_first_byte && r_phase == PH_LABEL) |-> !o_result_valid)
        else $error("result emitted inside a label");

endmodule

`default_nettype wire

[rtl/core/drrp_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module drrp_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire drrp_pkg::t_result  i_result,
    output logic                    o_ready,
    output logic                    o_valid,
    output drrp_pkg::t_result       o_result,
    input  wire logic               i_ready
);

    logic              r_valid;
    drrp_pkg::t_result r_result;

    // room when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[rtl/core/dns_resource_record_parser.sv]
// one record byte per input word, one input word accepted per cycle while the slave side is not stalled
// a result word appears on the master side in the cycle after the byte that ends the record is accepted
// throughput is set by the single registered pass through the parser state update
// the slave side stalls only while a result word waits on the master side
// synchronous active-low reset returns the parser to idle, drops any held result word
// and sets the accepted class to 1
`timescale 1ns / 1ps
`default_nettype none

module dns_resource_record_parser (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [14:0]  i_cfg_wr_data,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // record_offset[15:0], bytes_available[31:16], data_byte[39:32]
    input  wire logic [39:0]  i_s_axis_tdata,
    // first_byte[0]
    input  wire logic [0:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // rr_type[15:0], flush_bit[16], time_to_live[48:17], data_length[64:49],
    // data_offset[80:65], record_length[96:81], zero fill[103:97]
    output logic [103:0]      o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]        o_m_axis_tuser
);

    logic [drrp_pkg::CLASS_W-1:0] r_accepted_class;
    logic                         in_accept;
    logic                         res_valid;
    drrp_pkg::t_result            res;
    drrp_pkg::t_result            out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_class <= 15'd1;
        end else if (i_cfg_wr_en) begin
            r_accepted_class <= i_cfg_wr_data;
        end
    end

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    drrp_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_first_byte      (i_s_axis_tuser[0]),
        .i_record_offset   (i_s_axis_tdata[15:0]),
        .i_bytes_available (i_s_axis_tdata[31:16]),
        .i_data_byte       (i_s_axis_tdata[39:32]),
        .i_accepted_class  (r_accepted_class),
        .o_result_valid    (res_valid),
        .o_result          (res)
    );

    drrp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_result (res),
        .o_ready  (o_s_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_res),
        .i_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {7'd0, out_res.record_length, out_res.data_offset,
                             out_res.data_length, out_res.time_to_live,
                             out_res.flush_bit, out_res.rr_type};
    assign o_m_axis_tuser = out_res.status;

endmodule

`default_nettype wire
